// ----- rtl/core/text_console_writer_defines.svh -----
// Assertion macros shared by the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define TCW_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text_console_writer: assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define TCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text_console_writer: assertion failed");

`endif

// ----- rtl/core/tcw_pkg.sv -----
// Shared types, codes and constants of the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int SCREEN_COLUMNS_DEF = 80;
    localparam int SCREEN_CELLS_DEF   = 2000;
    localparam int TAB_STOP_DEF       = 8;

    // Row accumulator width while a set-cursor request is normalized.
    localparam int SET_ROW_W = 6;

    localparam logic [7:0] ATTR_GREEN     = 8'h0A;
    localparam logic [7:0] SPACE_CODE     = 8'h20;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [15:0] BLANK_CELL    = {ATTR_GREEN, SPACE_CODE};

    typedef enum logic [2:0] {
        OP_PUT_CHAR   = 3'd0,
        OP_PUT_RAW    = 3'd1,
        OP_SET_CURSOR = 3'd2,
        OP_CLEAR      = 3'd3,
        OP_READ       = 3'd4
    } tcw_op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_SET,
        ST_CLEAR,
        ST_READ,
        ST_DONE
    } tcw_state_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  char_code;
        logic [7:0]  color;
        logic [6:0]  column;
        logic [4:0]  row;
        logic [10:0] cell_address;
    } tcw_in_t;

    typedef struct packed {
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
        logic [15:0] read_cell;
    } tcw_out_t;

    // Commands from the sequencer to the cursor unit.
    typedef struct packed {
        logic home;
        logic advance;
        logic retreat;
        logic set_start;
    } tcw_cur_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/tcw_cell_store.sv -----
// Screen cell memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tcw_cell_store #(
    parameter int DEPTH = tcw_pkg::SCREEN_CELLS_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [15:0]   wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [15:0]   rd_data
);

    logic [15:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; rd_data is registered and holds its value while rd_en is low.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tcw_cursor.sv -----
// Cursor unit: linear position with column, row and tab phase kept in step.
`timescale 1ns / 1ps
`default_nettype none

module tcw_cursor #(
    parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_CELLS   = tcw_pkg::SCREEN_CELLS_DEF,
    parameter int TAB_STOP       = tcw_pkg::TAB_STOP_DEF,
    localparam int PW = $clog2(SCREEN_CELLS + 1),
    localparam int AW = $clog2(SCREEN_CELLS),
    localparam int CW = $clog2(SCREEN_COLUMNS),
    localparam int RW = $clog2(SCREEN_CELLS / SCREEN_COLUMNS + 2),
    localparam int TW = $clog2(TAB_STOP)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tcw_pkg::tcw_cur_cmd_t cmd,
    input  wire logic [4:0]           set_row,
    input  wire logic [6:0]           set_column,
    output logic      [PW-1:0]        pos,
    output logic      [CW-1:0]        col,
    output logic      [RW-1:0]        row,
    output logic      [TW-1:0]        tab,
    output logic      [AW-1:0]        adv_addr,
    output logic      [AW-1:0]        back_addr,
    output logic                      set_done
);

    localparam int SET_W    = $clog2(31 * SCREEN_COLUMNS + 128);
    localparam int RECIP_SH = SET_W + TW + 1;
    localparam int RECIP    = (2 ** RECIP_SH + TAB_STOP - 1) / TAB_STOP;
    localparam int PROD_W   = SET_W + RECIP_SH;
    localparam int END_ROW  = SCREEN_CELLS / SCREEN_COLUMNS;
    localparam int END_COL  = SCREEN_CELLS % SCREEN_COLUMNS;
    localparam int END_TAB  = SCREEN_CELLS % TAB_STOP;

    logic [PW-1:0] pos_reg, pos_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [TW-1:0] tab_reg, tab_next;

    logic [SET_W-1:0]             p_reg, p_next;
    logic [tcw_pkg::SET_ROW_W-1:0] rowacc_reg, rowacc_next;
    logic [6:0]                   colrem_reg, colrem_next;
    logic [SET_W-1:0]             quot_reg, quot_next;
    logic [1:0]                   step_cnt_reg, step_cnt_next;
    logic [TW-1:0]                rem_reg, rem_next;
    logic                         set_active_reg, set_active_next;

    logic          wrap;
    logic [PW-1:0] base_pos;
    logic [CW-1:0] base_col;
    logic [RW-1:0] base_row;
    logic [TW-1:0] base_tab;
    logic          col_last;
    logic          col_spill;
    logic [PROD_W-1:0] quot_prod;
    logic [SET_W-1:0]  quot_mul;
    logic              saturate;

    // A cursor at the end of the store wraps to zero before a cell is written.
    assign wrap     = (pos_reg == PW'(SCREEN_CELLS));
    assign base_pos = wrap ? '0 : pos_reg;
    assign base_col = wrap ? '0 : col_reg;
    assign base_row = wrap ? '0 : row_reg;
    assign base_tab = wrap ? '0 : tab_reg;
    assign col_last = (base_col == CW'(SCREEN_COLUMNS - 1));

    assign adv_addr  = AW'(base_pos);
    assign back_addr = AW'(pos_reg - 1'b1);

    // Set-cursor normalization: column spill by subtraction, tab phase by a
    // reciprocal multiply for the quotient and a multiply-back on the next cycle.
    assign col_spill = (32'(colrem_reg) >= 32'(SCREEN_COLUMNS));
    assign quot_prod = PROD_W'(p_reg) * PROD_W'(RECIP);
    assign quot_mul  = SET_W'(quot_reg) * SET_W'(TAB_STOP);
    assign saturate  = (32'(p_reg) > 32'(SCREEN_CELLS));
    assign set_done  = set_active_reg && (step_cnt_reg == '0) && !col_spill;

    // Next-state logic for the cursor and the normalization registers.
    always_comb
    begin
        pos_next        = pos_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        tab_next        = tab_reg;
        p_next          = p_reg;
        rowacc_next     = rowacc_reg;
        colrem_next     = colrem_reg;
        quot_next       = quot_reg;
        step_cnt_next   = step_cnt_reg;
        rem_next        = rem_reg;
        set_active_next = set_active_reg;

        priority if (cmd.home)
        begin
            pos_next = '0;
            col_next = '0;
            row_next = '0;
            tab_next = '0;
        end
        else if (cmd.advance)
        begin
            pos_next = PW'(base_pos + 1'b1);
            col_next = col_last ? '0 : CW'(base_col + 1'b1);
            row_next = col_last ? RW'(base_row + 1'b1) : base_row;
            tab_next = (base_tab == TW'(TAB_STOP - 1)) ? '0 : TW'(base_tab + 1'b1);
        end
        else if (cmd.retreat)
        begin
            pos_next = PW'(pos_reg - 1'b1);
            if (col_reg == '0)
            begin
                col_next = CW'(SCREEN_COLUMNS - 1);
                row_next = RW'(row_reg - 1'b1);
            end
            else
            begin
                col_next = CW'(col_reg - 1'b1);
            end
            tab_next = (tab_reg == '0) ? TW'(TAB_STOP - 1) : TW'(tab_reg - 1'b1);
        end
        else if (cmd.set_start)
        begin
            p_next          = SET_W'(SET_W'(set_row) * SET_W'(SCREEN_COLUMNS)
                              + SET_W'(set_column));
            rowacc_next     = tcw_pkg::SET_ROW_W'(set_row);
            colrem_next     = set_column;
            step_cnt_next   = 2'd2;
            rem_next        = '0;
            set_active_next = 1'b1;
        end
        else if (set_active_reg)
        begin
            if (set_done)
            begin
                set_active_next = 1'b0;
                if (saturate)
                begin
                    pos_next = PW'(SCREEN_CELLS);
                    row_next = RW'(END_ROW);
                    col_next = CW'(END_COL);
                    tab_next = TW'(END_TAB);
                end
                else
                begin
                    pos_next = PW'(p_reg);
                    row_next = RW'(rowacc_reg);
                    col_next = CW'(colrem_reg);
                    tab_next = rem_reg;
                end
            end
            else
            begin
                if (col_spill)
                begin
                    colrem_next = 7'(colrem_reg - 7'(SCREEN_COLUMNS));
                    rowacc_next = tcw_pkg::SET_ROW_W'(rowacc_reg + 1'b1);
                end
                // First the quotient by the tab stop, then the remainder.
                if (step_cnt_reg == 2'd2)
                begin
                    quot_next     = SET_W'(quot_prod >> RECIP_SH);
                    step_cnt_next = 2'd1;
                end
                else if (step_cnt_reg == 2'd1)
                begin
                    rem_next      = TW'(p_reg - quot_mul);
                    step_cnt_next = 2'd0;
                end
            end
        end
    end

    // Cursor and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            tab_reg        <= '0;
            step_cnt_reg   <= '0;
            set_active_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            tab_reg        <= tab_next;
            step_cnt_reg   <= step_cnt_next;
            set_active_reg <= set_active_next;
        end
    end

    // Normalization working registers.
    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        rowacc_reg <= rowacc_next;
        colrem_reg <= colrem_next;
        quot_reg   <= quot_next;
        rem_reg    <= rem_next;
    end

    assign pos = pos_reg;
    assign col = col_reg;
    assign row = row_reg;
    assign tab = tab_reg;

endmodule

`default_nettype wire

// ----- rtl/core/text_console_writer.sv -----
// Text console writer top level: sequencer, cursor unit and cell store.
// Flow: an accepted transaction passes through ST_EXEC to ST_DONE, and an in-range read adds ST_READ;
// newline and tab pass through ST_FILL, which writes one blank per cycle (up to a row), set cursor
// waits in ST_SET for the cursor normalization and clear sweeps the store in ST_CLEAR, one cell per cycle.
// Throughput: one transaction in work at a time; in_ready rises together with out_valid.
// Reset: rst_n clears control and cursor, then the ST_INIT sweep blanks the store.
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_writer_defines.svh"

module text_console_writer #(
    parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_CELLS   = tcw_pkg::SCREEN_CELLS_DEF,
    parameter int TAB_STOP       = tcw_pkg::TAB_STOP_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire tcw_pkg::tcw_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output tcw_pkg::tcw_out_t     out_data
);

    localparam int PW       = $clog2(SCREEN_CELLS + 1);
    localparam int AW       = $clog2(SCREEN_CELLS);
    localparam int CW       = $clog2(SCREEN_COLUMNS);
    localparam int RW       = $clog2(SCREEN_CELLS / SCREEN_COLUMNS + 2);
    localparam int TW       = $clog2(TAB_STOP);
    localparam int FILL_MAX = (SCREEN_COLUMNS > TAB_STOP) ? SCREEN_COLUMNS : TAB_STOP;
    localparam int FW       = $clog2(FILL_MAX + 1);

    tcw_pkg::tcw_state_t   state_reg, state_next;
    tcw_pkg::tcw_in_t      item_reg, item_next;
    tcw_pkg::tcw_out_t     out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    logic [FW-1:0]         fill_cnt_reg, fill_cnt_next;
    logic [AW-1:0]         clr_addr_reg, clr_addr_next;
    logic [15:0]           rd_reg, rd_next;
    logic                  out_load;

    tcw_pkg::tcw_cur_cmd_t cur_cmd;
    logic [PW-1:0]         cur_pos;
    logic [CW-1:0]         cur_col;
    logic [RW-1:0]         cur_row;
    logic [TW-1:0]         cur_tab;
    logic [AW-1:0]         adv_addr;
    logic [AW-1:0]         back_addr;
    logic                  set_done;

    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    logic [15:0]           mem_wr_data;
    logic                  mem_rd_en;
    logic [AW-1:0]         mem_rd_addr;
    logic [15:0]           mem_rd_data;

    tcw_cursor #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_CELLS   (SCREEN_CELLS),
        .TAB_STOP       (TAB_STOP)
    ) u_cursor (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cur_cmd),
        .set_row    (item_reg.row),
        .set_column (item_reg.column),
        .pos        (cur_pos),
        .col        (cur_col),
        .row        (cur_row),
        .tab        (cur_tab),
        .adv_addr   (adv_addr),
        .back_addr  (back_addr),
        .set_done   (set_done)
    );

    tcw_cell_store #(
        .DEPTH (SCREEN_CELLS)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign in_ready  = (state_reg == tcw_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_load  = (state_reg == tcw_pkg::ST_DONE) && (!out_valid_reg || out_ready);

    // Sequencer: next state, cursor commands and store accesses.
    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        fill_cnt_next = fill_cnt_reg;
        clr_addr_next = clr_addr_reg;
        rd_next       = rd_reg;
        cur_cmd       = '0;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = adv_addr;
        mem_wr_data   = tcw_pkg::BLANK_CELL;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = AW'(item_reg.cell_address);

        unique case (state_reg)
            tcw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = tcw_pkg::ST_EXEC;
                end
            end

            tcw_pkg::ST_EXEC:
            begin
                rd_next    = '0;
                state_next = tcw_pkg::ST_DONE;
                unique case (item_reg.op)
                    tcw_pkg::OP_PUT_CHAR:
                    begin
                        unique case (item_reg.char_code)
                            tcw_pkg::CHAR_BACKSPACE:
                            begin
                                // Backspace at the home position does nothing.
                                if (cur_pos != '0)
                                begin
                                    cur_cmd.retreat = 1'b1;
                                    mem_wr_en       = 1'b1;
                                    mem_wr_addr     = back_addr;
                                end
                            end
                            tcw_pkg::CHAR_NEWLINE:
                            begin
                                fill_cnt_next = FW'(SCREEN_COLUMNS) - FW'(cur_col);
                                state_next    = tcw_pkg::ST_FILL;
                            end
                            tcw_pkg::CHAR_TAB:
                            begin
                                fill_cnt_next = FW'(TAB_STOP) - FW'(cur_tab);
                                state_next    = tcw_pkg::ST_FILL;
                            end
                            default:
                            begin
                                cur_cmd.advance = 1'b1;
                                mem_wr_en       = 1'b1;
                                mem_wr_data     = {tcw_pkg::ATTR_GREEN, item_reg.char_code};
                            end
                        endcase
                    end
                    tcw_pkg::OP_PUT_RAW:
                    begin
                        cur_cmd.advance = 1'b1;
                        mem_wr_en       = 1'b1;
                        mem_wr_data     = {item_reg.color, item_reg.char_code};
                    end
                    tcw_pkg::OP_SET_CURSOR:
                    begin
                        cur_cmd.set_start = 1'b1;
                        state_next        = tcw_pkg::ST_SET;
                    end
                    tcw_pkg::OP_CLEAR:
                    begin
                        clr_addr_next = '0;
                        state_next    = tcw_pkg::ST_CLEAR;
                    end
                    tcw_pkg::OP_READ:
                    begin
                        // Addresses past the store read as zero.
                        if (32'(item_reg.cell_address) < 32'(SCREEN_CELLS))
                        begin
                            mem_rd_en  = 1'b1;
                            state_next = tcw_pkg::ST_READ;
                        end
                    end
                    default:
                    begin
                        state_next = tcw_pkg::ST_DONE;
                    end
                endcase
            end

            tcw_pkg::ST_FILL:
            begin
                // One blank per cycle; each blank wraps the cursor on its own.
                cur_cmd.advance = 1'b1;
                mem_wr_en       = 1'b1;
                fill_cnt_next   = FW'(fill_cnt_reg - 1'b1);
                if (fill_cnt_reg == FW'(1))
                begin
                    state_next = tcw_pkg::ST_DONE;
                end
            end

            tcw_pkg::ST_SET:
            begin
                if (set_done)
                begin
                    state_next = tcw_pkg::ST_DONE;
                end
            end

            tcw_pkg::ST_INIT,
            tcw_pkg::ST_CLEAR:
            begin
                // Sweep the store with blanks, one cell per cycle.
                mem_wr_en     = 1'b1;
                mem_wr_addr   = clr_addr_reg;
                clr_addr_next = AW'(clr_addr_reg + 1'b1);
                if (clr_addr_reg == AW'(SCREEN_CELLS - 1))
                begin
                    clr_addr_next = '0;
                    if (state_reg == tcw_pkg::ST_CLEAR)
                    begin
                        cur_cmd.home = 1'b1;
                        state_next   = tcw_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = tcw_pkg::ST_IDLE;
                    end
                end
            end

            tcw_pkg::ST_READ:
            begin
                rd_next    = mem_rd_data;
                state_next = tcw_pkg::ST_DONE;
            end

            tcw_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Output register loads the finished result.
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_next.cursor_column = 7'(cur_col);
            out_next.cursor_row    = 5'(cur_row);
            out_next.read_cell     = rd_reg;
            out_valid_next         = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::ST_INIT;
            out_valid_reg <= 1'b0;
            fill_cnt_reg  <= '0;
            clr_addr_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            fill_cnt_reg  <= fill_cnt_next;
            clr_addr_reg  <= clr_addr_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        rd_reg   <= rd_next;
        out_reg  <= out_next;
    end

    // Checks on the cursor unit and the store accesses.
    `TCW_ASSERT_IMPLIES(a_pos_in_range, 1'b1, 32'(cur_pos) <= 32'(SCREEN_CELLS))
    `TCW_ASSERT_IMPLIES(a_cursor_coherent, 1'b1,
        32'(cur_row) * 32'(SCREEN_COLUMNS) + 32'(cur_col) == 32'(cur_pos))
    `TCW_ASSERT_IMPLIES(a_write_in_range, mem_wr_en, 32'(mem_wr_addr) < 32'(SCREEN_CELLS))
    `TCW_ASSERT_IMPLIES(a_fill_count_live, state_reg == tcw_pkg::ST_FILL, fill_cnt_reg != '0)
    `TCW_ASSERT_NEXT(a_read_captured, mem_rd_en, state_reg == tcw_pkg::ST_READ)

endmodule

`default_nettype wire
